/* sv/krs_pkg.sv */
// ----------------------------------------------------------------------------
// krs_pkg
// Shared constants for the k-th remaining select/remove block.
// ----------------------------------------------------------------------------
`default_nettype none

package krs_pkg;

    localparam int unsigned FIELD_W       = 11;
    localparam int unsigned MAX_ITEMS_DEF = 1024;
    localparam int unsigned MIN_ITEMS     = 2;

    // Per-row epoch tag; all ones marks a row as stale.
    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = EPOCH_STALE - EPOCH_W'(1);

    localparam logic ACT_REFILL = 1'b0;
    localparam logic ACT_TAKE   = 1'b1;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [EPOCH_W-1:0] t_epoch;

endpackage

`default_nettype wire

/* sv/kth_remaining_select_remove.sv */
// ----------------------------------------------------------------------------
// kth_remaining_select_remove
// Order-statistic counting tree: removes and returns the k-th smallest
// remaining position, or refills all positions 1..items_in_use.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | i_in_valid / o_in_stall    | i_action, i_rank
//  out     | o_out_valid / i_out_stall  | o_position, o_remaining, o_rank_error
//  cfg     | i_cfg_we                   | i_cfg_wdata (items_in_use)
//
//  A take walks one cell per tree level (row read into a register at the
//  transfer, count update while the next cell reads); the result is
//  registered from the last cell's output.
//  Refill and rank errors give their result the cycle after the transfer.
//  After reset all 2**(clog2(MAX_ITEMS)-1) row addresses (512 by default)
//  are swept stale with input stalled; every 255th refill repeats the sweep.
//  One item in flight; input stalls until the result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_remaining_select_remove #(
    parameter int unsigned MAX_ITEMS = krs_pkg::MAX_ITEMS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire krs_pkg::t_field i_cfg_wdata,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_action,
    input  wire krs_pkg::t_field i_rank,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output krs_pkg::t_field      o_position,
    output krs_pkg::t_field      o_remaining,
    output logic                 o_rank_error
);
    import krs_pkg::*;

    localparam int unsigned LEVELS = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W  = LEVELS + 1;
    localparam int unsigned SW     = (LEVELS > 1) ? LEVELS - 1 : 1;
    localparam int unsigned CMP_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

    logic [CNT_W-1:0] r_items;
    logic [CNT_W-1:0] r_remaining;
    t_epoch           r_epoch;
    logic             r_sweep;
    logic [SW-1:0]    r_sweep_addr;
    logic             r_busy;
    logic             r_out_valid;
    t_field           r_position;
    t_field           r_out_remaining;
    logic             r_rank_error;

    logic             in_xfer;
    logic             out_xfer;
    logic             bad_rank;
    logic             refill;
    logic             take_start;
    logic             chain_done;
    logic [CNT_W-1:0] cfg_items;

    logic             v_valid [LEVELS+1];
    logic [LEVELS-1:0] v_node [LEVELS+1];
    logic [LEVELS:0]  v_rank  [LEVELS+1];

    always_comb begin
        o_in_stall = r_busy | r_sweep | r_out_valid;
        in_xfer    = i_in_valid & ~o_in_stall;
        out_xfer   = r_out_valid & ~i_out_stall;
        bad_rank   = (i_rank == '0) || (CMP_W'(i_rank) > CMP_W'(r_remaining));
        refill     = (in_xfer && i_action == ACT_REFILL) || i_cfg_we;
        take_start = in_xfer && i_action == ACT_TAKE && !bad_rank;
        chain_done = v_valid[LEVELS];
        if (i_cfg_wdata < FIELD_W'(MIN_ITEMS)) begin
            cfg_items = CNT_W'(MIN_ITEMS);
        end else if (32'(i_cfg_wdata) > MAX_ITEMS) begin
            cfg_items = CNT_W'(MAX_ITEMS);
        end else begin
            cfg_items = CNT_W'(i_cfg_wdata);
        end
    end

    assign v_valid[0] = take_start;
    assign v_node[0]  = '0;
    assign v_rank[0]  = (LEVELS+1)'(i_rank);

    for (genvar d = 0; d < LEVELS; d++) begin : g_cell
        krs_cell #(
            .LEVELS (LEVELS),
            .DEPTH  (d)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (v_valid[d]),
            .i_node       (v_node[d]),
            .i_rank       (v_rank[d]),
            .i_items      (r_items),
            .i_epoch      (r_epoch),
            .i_sweep      (r_sweep),
            .i_sweep_addr (LEVELS'(r_sweep_addr)),
            .o_valid      (v_valid[d+1]),
            .o_node       (v_node[d+1]),
            .o_rank       (v_rank[d+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items      <= CNT_W'(MAX_ITEMS);
            r_remaining  <= CNT_W'(MAX_ITEMS);
            r_epoch      <= '0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + SW'(1);
                if (r_sweep_addr == '1) begin
                    r_sweep <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_items     <= cfg_items;
                r_remaining <= cfg_items;
            end else if (in_xfer && i_action == ACT_REFILL) begin
                r_remaining <= r_items;
            end else if (chain_done) begin
                r_remaining <= r_remaining - CNT_W'(1);
            end
            // Stale rows fall back to full counts; a sweep is needed only on wrap.
            if (refill && !r_sweep) begin
                if (r_epoch == EPOCH_LAST) begin
                    r_epoch      <= '0;
                    r_sweep      <= 1'b1;
                    r_sweep_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end
            if (take_start) begin
                r_busy <= 1'b1;
            end else if (chain_done) begin
                r_busy <= 1'b0;
            end
            if ((in_xfer && !take_start) || chain_done) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_xfer && !take_start) begin
            r_position      <= '0;
            r_rank_error    <= (i_action == ACT_TAKE);
            r_out_remaining <= (i_action == ACT_TAKE) ? FIELD_W'(r_remaining)
                                                      : FIELD_W'(r_items);
        end else if (chain_done) begin
            r_position      <= FIELD_W'(32'(v_node[LEVELS]) + 32'd1);
            r_rank_error    <= 1'b0;
            r_out_remaining <= FIELD_W'(r_remaining - CNT_W'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_position   = r_position;
    assign o_remaining  = r_out_remaining;
    assign o_rank_error = r_rank_error;

`ifndef SYNTH
    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_done |-> r_busy)
        else $error("tree walk finished with no take in flight");

    a_error_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rank_error) |-> (r_position == '0))
        else $error("rank error with a non-zero position");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= r_items)
        else $error("remaining count above tree size");

    a_take_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_done |=> (r_remaining == $past(r_remaining) - CNT_W'(1)))
        else $error("take did not remove exactly one position");
`endif

endmodule

`default_nettype wire

/* sv/krs_cell.sv */
// ----------------------------------------------------------------------------
// krs_cell
// One tree level: holds the child counts of every node at its depth, picks
// the branch holding the requested rank and takes one off the chosen child.
// ----------------------------------------------------------------------------
`default_nettype none

module krs_cell #(
    parameter int unsigned LEVELS = 10,
    parameter int unsigned DEPTH  = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [LEVELS-1:0]     i_node,
    input  wire logic [LEVELS:0]       i_rank,
    input  wire logic [LEVELS:0]       i_items,
    input  wire krs_pkg::t_epoch       i_epoch,
    input  wire logic                  i_sweep,
    input  wire logic [LEVELS-1:0]     i_sweep_addr,
    output logic                       o_valid,
    output logic [LEVELS-1:0]          o_node,
    output logic [LEVELS:0]            o_rank
);
    import krs_pkg::*;

    localparam int unsigned RW      = (DEPTH == 0) ? 1 : DEPTH;
    localparam int unsigned ROWS    = 1 << RW;
    localparam int unsigned CW      = LEVELS - DEPTH;
    localparam int unsigned SPAN    = 1 << (CW - 1);
    localparam int unsigned ENTRY_W = EPOCH_W + 2 * CW;

    logic [ENTRY_W-1:0] r_mem [ROWS];
    logic [ENTRY_W-1:0] r_rd;
    logic               r_busy;
    logic [LEVELS-1:0]  r_node;
    logic [LEVELS:0]    r_rank;

    t_epoch          rd_tag;
    logic            stale;
    logic [LEVELS:0] base_l;
    logic [LEVELS:0] base_r;
    logic [CW-1:0]   left;
    logic [CW-1:0]   right;
    logic            go_left;
    logic [CW-1:0]   n_left;
    logic [CW-1:0]   n_right;

    // Count of present positions in a child span starting at lo (zero based).
    function automatic logic [CW-1:0] def_count(logic [LEVELS:0] lo, logic [LEVELS:0] items);
        logic [LEVELS:0] diff;
        diff = items - lo;
        if (items <= lo) begin
            return '0;
        end else if (diff >= (LEVELS+1)'(SPAN)) begin
            return CW'(SPAN);
        end else begin
            return diff[CW-1:0];
        end
    endfunction

    always_comb begin
        rd_tag  = r_rd[ENTRY_W-1 -: EPOCH_W];
        stale   = (rd_tag != i_epoch);
        base_l  = (LEVELS+1)'(r_node[RW-1:0]) << CW;
        base_r  = base_l + (LEVELS+1)'(SPAN);
        left    = stale ? def_count(base_l, i_items) : r_rd[2*CW-1 -: CW];
        right   = stale ? def_count(base_r, i_items) : r_rd[CW-1:0];
        go_left = ((LEVELS+1)'(left) >= r_rank);
        n_left  = go_left ? left - CW'(1) : left;
        n_right = go_left ? right : right - CW'(1);
        o_valid = r_busy;
        o_node  = (r_node << 1) | LEVELS'(!go_left);
        o_rank  = go_left ? r_rank : r_rank - (LEVELS+1)'(left);
    end

    always_ff @(posedge i_clk) begin
        if (i_sweep) begin
            r_mem[i_sweep_addr[RW-1:0]] <= {EPOCH_STALE, {(2*CW){1'b0}}};
        end else if (r_busy) begin
            r_mem[r_node[RW-1:0]] <= {i_epoch, n_left, n_right};
        end
        if (i_valid) begin
            r_rd <= r_mem[i_node[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_valid;
        end
        if (i_valid) begin
            r_node <= i_node;
            r_rank <= i_rank;
        end
    end

endmodule

`default_nettype wire

/* tb/kth_remaining_select_remove_tb.sv */
// ----------------------------------------------------------------------------
// kth_remaining_select_remove_tb
// Self-checking bench for the k-th remaining select/remove tree. A presence
// map of positions 1..span predicts every result: take removes the k-th
// present position, refill restores all, bad ranks flag an error. A short
// directed table is followed by randomised phases over several spans and
// idle patterns on both channels; every output transfer is compared in order.
// ----------------------------------------------------------------------------

module kth_remaining_select_remove_tb;

    import krs_pkg::*;

    localparam int unsigned MAX_POS     = MAX_ITEMS_DEF;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned PHASE_ITEMS = 66;

    typedef struct packed {
        t_field position;
        t_field remaining;
        logic   rank_error;
    } t_result;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      act;
        t_field    value;
        bit        typed;
        t_result   want;
    } t_row;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } t_idle_mode;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   cfg_we      = 1'b0;
    t_field cfg_wdata   = '0;
    logic   in_valid    = 1'b0;
    logic   in_stall;
    logic   action      = ACT_REFILL;
    t_field rank        = '0;
    logic   out_valid;
    logic   out_stall   = 1'b0;
    t_field position;
    t_field remaining;
    logic   rank_error;

    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned fails    = 0;
    int unsigned cycles   = 0;

    bit          present [1:MAX_POS];
    int unsigned span;
    int unsigned left;

    t_result due_results [$];
    t_row    directed    [$];

    always #2 i_clk = ~i_clk;

    kth_remaining_select_remove u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (action),
        .i_rank       (rank),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_position   (position),
        .o_remaining  (remaining),
        .o_rank_error (rank_error)
    );

    function automatic void refill_positions();
        for (int unsigned i = 1; i <= MAX_POS; i++) begin
            present[i] = (i <= span);
        end
        left = span;
    endfunction

    function automatic t_result select_remove(input logic act, input t_field k);
        t_result     res;
        int unsigned seen;
        res = '0;
        seen = 0;
        if (act == ACT_REFILL) begin
            refill_positions();
        end else if (k == 0 || k > left) begin
            res.rank_error = 1'b1;
        end else begin
            for (int unsigned i = 1; i <= span; i++) begin
                if (present[i]) begin
                    seen++;
                    if (seen == k) begin
                        present[i] = 1'b0;
                        left--;
                        res.position = t_field'(i);
                        break;
                    end
                end
            end
        end
        res.remaining = t_field'(left);
        return res;
    endfunction

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
            IDLE_SEND: begin send_pct = 85; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 85; end
            default:   begin send_pct = 25; recv_pct = 25; end
        endcase
    endtask

    // Leaves valid high after the transfer so back-to-back items never
    // lower and raise it in the same step.
    task automatic send_item(input logic act, input t_field k, input bit typed,
                             input t_result want);
        t_result predicted;
        predicted = select_remove(act, k);
        due_results.push_back(typed ? want : predicted);
        if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_pct);
        end
        in_valid <= 1'b1;
        action   <= act;
        rank     <= k;
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
    endtask

    task automatic write_span(input t_field value);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        do @(negedge i_clk); while (in_stall);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        span = (value < MIN_ITEMS) ? MIN_ITEMS : (value > MAX_POS) ? MAX_POS : value;
        refill_positions();
    endtask

    task automatic add_row(input t_row_kind kind, input logic act, input t_field value,
                           input bit typed, input t_field pos, input t_field rem,
                           input logic err);
        t_row r;
        r.kind  = kind;
        r.act   = act;
        r.value = value;
        r.typed = typed;
        r.want  = '{position: pos, remaining: rem, rank_error: err};
        directed.push_back(r);
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("kth_remaining_select_remove_tb NOT OK");
            $finish;
        end
    end

    // Sampled at the falling edge ahead of the rising edge that completes the transfer.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result pos=%0d rem=%0d err=%0b",
                         $time, position, remaining, rank_error);
                fails++;
            end else begin
                want = due_results.pop_front();
                if (position !== want.position) begin
                    $display("%0t: position exp %0d got %0d", $time, want.position, position);
                    fails++;
                end
                if (remaining !== want.remaining) begin
                    $display("%0t: remaining exp %0d got %0d",
                             $time, want.remaining, remaining);
                    fails++;
                end
                if (rank_error !== want.rank_error) begin
                    $display("%0t: rank_error exp %0b got %0b",
                             $time, want.rank_error, rank_error);
                    fails++;
                end
            end
        end
    end

    initial begin
        t_field     span_sel [8];
        t_idle_mode mode_sel [8];
        int unsigned pick;
        t_field      k;

        span = MAX_POS;
        refill_positions();

        add_row(ROW_ITEM, ACT_TAKE,   11'd1,    1, 11'd1,    11'd1023, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd0,    1, 11'd0,    11'd1023, 1'b1);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1024, 1, 11'd0,    11'd1023, 1'b1);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1023, 1, 11'd1024, 11'd1022, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd2047, 1, 11'd0,    11'd1022, 1'b1);
        add_row(ROW_ITEM, ACT_TAKE,   11'd512,  0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1,    0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_REFILL, 11'd1365, 1, 11'd0,    11'd1024, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1024, 1, 11'd1024, 11'd1023, 1'b0);
        add_row(ROW_CFG,  ACT_TAKE,   11'd0,    0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd2,    1, 11'd2,    11'd1,    1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd2,    1, 11'd0,    11'd1,    1'b1);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1,    1, 11'd1,    11'd0,    1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1,    1, 11'd0,    11'd0,    1'b1);
        add_row(ROW_ITEM, ACT_TAKE,   11'd0,    1, 11'd0,    11'd0,    1'b1);
        add_row(ROW_ITEM, ACT_REFILL, 11'd682,  1, 11'd0,    11'd2,    1'b0);
        add_row(ROW_CFG,  ACT_TAKE,   11'd2047, 0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1024, 1, 11'd1024, 11'd1023, 1'b0);
        add_row(ROW_CFG,  ACT_TAKE,   11'd1025, 0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd700,  0, '0, '0, 1'b0);
        add_row(ROW_CFG,  ACT_TAKE,   11'd1,    0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_REFILL, 11'd0,    1, 11'd0,    11'd2,    1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd1,    1, 11'd1,    11'd1,    1'b0);
        add_row(ROW_CFG,  ACT_TAKE,   11'd3,    0, '0, '0, 1'b0);
        add_row(ROW_ITEM, ACT_TAKE,   11'd2,    0, '0, '0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(IDLE_NONE);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                write_span(directed[i].value);
            end else begin
                send_item(directed[i].act, directed[i].value, directed[i].typed,
                          directed[i].want);
            end
        end

        span_sel = '{11'd1024, 11'd2, 11'd5, 11'd2047,
                     11'd1, t_field'($urandom_range(3, 40)),
                     t_field'($urandom_range(41, 1023)), 11'd1024};
        mode_sel = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                     IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_RECV};

        for (int p = 0; p < 8; p++) begin
            write_span(span_sel[p]);
            set_idle(mode_sel[p]);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_item(ACT_REFILL, t_field'($urandom), 1'b0, '0);
                end else if (pick < 20 || left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       k = '0;
                        1:       k = t_field'(left + 1);
                        default: k = t_field'($urandom_range(left + 1, 2047));
                    endcase
                    send_item(ACT_TAKE, k, 1'b0, '0);
                end else begin
                    send_item(ACT_TAKE, t_field'($urandom_range(1, left)), 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fails == 0) begin
            $display("kth_remaining_select_remove_tb OK");
        end else begin
            $display("kth_remaining_select_remove_tb NOT OK");
        end
        $finish;
    end

endmodule
